FILE: src/ckuct_pkg.sv
// Shared types for the cheapest-units cost tree: controller states,
// controller-to-datapath commands and datapath status. No dependencies.
`default_nettype none
package ckuct_pkg;

   localparam int unsigned DemandWidth = 24;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned SumWidth    = 48;
   localparam int unsigned TotalWidth  = 64;

   typedef enum logic [1:0] {
      MODE_ADD  = 2'd0,
      MODE_REM  = 2'd1,
      MODE_TICK = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_CHK_WALK,
      S_CHK_RD,
      S_CHK_CMP,
      S_UPD_RD,
      S_UPD_WR,
      S_TICK_RD,
      S_TICK_CMP,
      S_LEAF_MUL,
      S_LEAF_ACC,
      S_TOTAL,
      S_OUT
   } state_type;

   typedef struct packed {
      logic clr_write;   // write zero at the clear counter and advance it
      logic load_item;   // capture request beat, set walk to root
      logic walk_init;   // return walk to root
      logic walk_step;   // descend toward the item price
      logic tick_step;   // descend by count compare, accumulate left side
      logic rd_left;     // read left child instead of current node
      logic upd_write;   // write back updated node
      logic leaf_mul;    // form leaf partial cost
      logic leaf_acc;    // add leaf cost to day cost
      logic total_add;   // add day cost to running total
      logic out_load;    // load result register
      logic out_reject;  // result is a rejection
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic at_leaf;
      logic bad_price;
      logic chk_fail;
      logic out_free;
      mode_type mode;
   } status_type;

endpackage
`default_nettype wire

FILE: src/ckuct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ckuct_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: src/ckuct_ctrl.sv
// Sequencer for the cost tree: clearing pass, update and tick walks,
// result hand-off. Uses ckuct_pkg command and status types.
`default_nettype none
module ckuct_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ckuct_pkg::status_type status,
   output ckuct_pkg::cmd_type        cmd
);

   ckuct_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ckuct_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ckuct_pkg::S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_done) begin
               state_in = ckuct_pkg::S_IDLE;
            end
         end
         ckuct_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ckuct_pkg::S_DISPATCH;
            end
         end
         ckuct_pkg::S_DISPATCH: begin
            unique case (status.mode)
               ckuct_pkg::MODE_NOP:  state_in = ckuct_pkg::S_IDLE;
               ckuct_pkg::MODE_TICK: state_in = ckuct_pkg::S_TICK_RD;
               ckuct_pkg::MODE_ADD: begin
                  state_in = status.bad_price ? ckuct_pkg::S_OUT : ckuct_pkg::S_CHK_RD;
               end
               ckuct_pkg::MODE_REM: begin
                  state_in = status.bad_price ? ckuct_pkg::S_OUT : ckuct_pkg::S_CHK_WALK;
               end
               default: state_in = ckuct_pkg::S_IDLE;
            endcase
         end
         ckuct_pkg::S_CHK_WALK: begin
            // find the leaf for the removal check
            if (status.at_leaf) begin
               state_in = ckuct_pkg::S_CHK_RD;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ckuct_pkg::S_CHK_RD: begin
            state_in = ckuct_pkg::S_CHK_CMP;
         end
         ckuct_pkg::S_CHK_CMP: begin
            if (status.chk_fail) begin
               state_in = ckuct_pkg::S_OUT;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = ckuct_pkg::S_UPD_RD;
            end
         end
         ckuct_pkg::S_UPD_RD: begin
            state_in = ckuct_pkg::S_UPD_WR;
         end
         ckuct_pkg::S_UPD_WR: begin
            cmd.upd_write = 1'b1;
            if (status.at_leaf) begin
               state_in = ckuct_pkg::S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = ckuct_pkg::S_UPD_RD;
            end
         end
         ckuct_pkg::S_TICK_RD: begin
            cmd.rd_left = !status.at_leaf;
            state_in    = status.at_leaf ? ckuct_pkg::S_LEAF_MUL : ckuct_pkg::S_TICK_CMP;
         end
         ckuct_pkg::S_TICK_CMP: begin
            cmd.tick_step = 1'b1;
            state_in      = ckuct_pkg::S_TICK_RD;
         end
         ckuct_pkg::S_LEAF_MUL: begin
            cmd.leaf_mul = 1'b1;
            state_in     = ckuct_pkg::S_LEAF_ACC;
         end
         ckuct_pkg::S_LEAF_ACC: begin
            cmd.leaf_acc = 1'b1;
            state_in     = ckuct_pkg::S_TOTAL;
         end
         ckuct_pkg::S_TOTAL: begin
            cmd.total_add = 1'b1;
            state_in      = ckuct_pkg::S_OUT;
         end
         ckuct_pkg::S_OUT: begin
            // hold until the result register frees up
            cmd.out_reject = (status.mode != ckuct_pkg::MODE_TICK);
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ckuct_pkg::S_IDLE;
            end
         end
         default: state_in = ckuct_pkg::S_CLEAR;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/ckuct_dp.sv
// Datapath of the cost tree: node count and price-sum memories, walk
// registers, day cost and running total, result register.
// Uses ckuct_pkg and ckuct_ram.
`default_nettype none
module ckuct_dp #(
   parameter int unsigned PRICE_LEVELS = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ckuct_pkg::cmd_type   cmd,
   output ckuct_pkg::status_type     status,
   input  wire logic [1:0]           req_mode,
   input  wire logic [10:0]          req_price,
   input  wire logic [23:0]          req_unit_count,
   input  wire logic                 csr_wr_en,
   input  wire logic [23:0]          csr_wr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [47:0]               rsp_day_cost,
   output logic [62:0]               rsp_running_total,
   output logic                      rsp_rejected
);

   localparam int unsigned Nodes = 2 << $clog2(PRICE_LEVELS);
   localparam int unsigned NW    = $clog2(Nodes);
   localparam int unsigned LW    = $clog2(PRICE_LEVELS + 1);
   localparam int unsigned PW    = (LW > 11) ? LW : 11;
   localparam int unsigned DW    = ckuct_pkg::DemandWidth;
   localparam int unsigned CW    = ckuct_pkg::CountWidth;
   localparam int unsigned SW    = ckuct_pkg::SumWidth;
   localparam int unsigned TW    = ckuct_pkg::TotalWidth;

   // item and walk registers
   ckuct_pkg::mode_type mode_ff;
   logic [PW-1:0] price_ff;
   logic [DW-1:0] count_ff;
   logic [SW-1:0] cost_ff;
   logic [NW-1:0] node_ff, node_in;
   logic [LW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [LW:0]   lo_hi_sum;
   logic [DW-1:0] need_ff, need_in;
   logic [SW-1:0] acc_ff, acc_in, prod_ff;
   logic [TW-1:0] total_ff;
   logic [DW-1:0] demand_ff, take;
   logic [NW-1:0] clr_cnt_ff;
   logic          rsp_valid_ff;
   logic [47:0]   rsp_day_cost_ff;
   logic [62:0]   rsp_running_total_ff;
   logic          rsp_rejected_ff;
   logic [PW+DW-1:0] cost_prod;
   logic [DW+LW-1:0] leaf_prod;

   // memory ports
   logic          wr_en;
   logic [NW-1:0] wr_addr, rd_addr, left_child, right_child;
   logic [CW-1:0] cnt_wr, cnt_rd;
   logic [SW-1:0] sum_wr, sum_rd;
   logic          go_left, price_left;

   ckuct_ram #(.WIDTH(CW), .DEPTH(Nodes)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cnt_wr),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   ckuct_ram #(.WIDTH(SW), .DEPTH(Nodes)) u_sum_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (sum_wr),
      .rd_addr (rd_addr),
      .rd_data (sum_rd)
   );

   // tree walk arithmetic
   assign lo_hi_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = lo_hi_sum[LW:1];
   assign left_child  = {node_ff[NW-2:0], 1'b0};
   assign right_child = {node_ff[NW-2:0], 1'b1};
   assign price_left  = price_ff <= PW'(mid);
   assign go_left     = cnt_rd > CW'(need_ff);
   assign take        = (cnt_rd > CW'(need_ff)) ? need_ff : cnt_rd[DW-1:0];

   // full-width products for the item cost and the leaf cost
   assign cost_prod = price_ff * count_ff;
   assign leaf_prod = take * lo_ff;

   assign rd_addr = cmd.rd_left ? left_child : node_ff;
   assign wr_en   = cmd.clr_write || cmd.upd_write;
   assign wr_addr = cmd.clr_write ? clr_cnt_ff : node_ff;

   // write-back data: zero on clear, else adjust by the item
   always_comb begin
      if (cmd.clr_write) begin
         cnt_wr = '0;
         sum_wr = '0;
      end else if (mode_ff == ckuct_pkg::MODE_ADD) begin
         cnt_wr = cnt_rd + CW'(count_ff);
         sum_wr = sum_rd + cost_ff;
      end else begin
         cnt_wr = cnt_rd - CW'(count_ff);
         sum_wr = sum_rd - cost_ff;
      end
   end

   // walk next values
   always_comb begin
      node_in = node_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      need_in = need_ff;
      acc_in  = acc_ff;
      if (cmd.load_item || cmd.walk_init) begin
         node_in = NW'(1);
         lo_in   = LW'(1);
         hi_in   = LW'(PRICE_LEVELS);
         if (cmd.load_item) begin
            need_in = demand_ff;
            acc_in  = '0;
         end
      end else if (cmd.walk_step) begin
         if (price_left) begin
            node_in = left_child;
            hi_in   = mid;
         end else begin
            node_in = right_child;
            lo_in   = mid + LW'(1);
         end
      end else if (cmd.tick_step) begin
         if (go_left) begin
            node_in = left_child;
            hi_in   = mid;
         end else begin
            node_in = right_child;
            lo_in   = mid + LW'(1);
            acc_in  = acc_ff + sum_rd;
            need_in = need_ff - cnt_rd[DW-1:0];
         end
      end else if (cmd.leaf_acc) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff  <= ckuct_pkg::mode_type'(req_mode);
         price_ff <= PW'(req_price);
         count_ff <= req_unit_count;
      end
      cost_ff <= SW'(cost_prod);
      node_ff <= node_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      need_ff <= need_in;
      acc_ff  <= acc_in;
      if (cmd.leaf_mul) begin
         prod_ff <= SW'(leaf_prod);
      end
      if (cmd.out_load) begin
         rsp_day_cost_ff      <= cmd.out_reject ? '0 : acc_ff;
         rsp_running_total_ff <= total_ff[62:0];
         rsp_rejected_ff      <= cmd.out_reject;
      end
   end

   // control-side registers: clear counter, demand, total, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         demand_ff    <= DW'(1);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_write) begin
            clr_cnt_ff <= clr_cnt_ff + NW'(1);
         end
         if (csr_wr_en) begin
            demand_ff <= csr_wr_data;
         end
         if (cmd.total_add) begin
            total_ff <= total_ff + TW'(acc_ff);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // status toward the controller
   always_comb begin
      status.clr_done  = &clr_cnt_ff;
      status.at_leaf   = lo_ff >= hi_ff;
      status.bad_price = (price_ff == '0) || (price_ff > PW'(PRICE_LEVELS));
      if (mode_ff == ckuct_pkg::MODE_ADD) begin
         status.chk_fail = ({1'b0, cnt_rd} + (CW + 1)'(count_ff)) > (CW + 1)'({CW{1'b1}});
      end else begin
         status.chk_fail = cnt_rd < CW'(count_ff);
      end
      status.out_free = !rsp_valid_ff || rsp_ready;
      status.mode     = mode_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_day_cost      = rsp_day_cost_ff;
   assign rsp_running_total = rsp_running_total_ff;
   assign rsp_rejected      = rsp_rejected_ff;

endmodule
`default_nettype wire

FILE: src/cheapest_k_units_cost_tree.sv
// Top level of the cheapest-units cost tree: controller plus datapath.
// Uses ckuct_pkg, ckuct_ctrl, ckuct_dp (which holds two ckuct_ram).
`default_nettype none
// The block keeps a segment tree over price levels 1..PRICE_LEVELS with a
// unit count and price sum per node, held in two single-port-pair RAMs of
// 2*2^ceil(log2 PRICE_LEVELS) entries. After reset it runs a clearing pass
// of one node per cycle and takes no request beat until done; csr writes
// are taken at any time. One item is processed at a time, bound by the
// RAM read latency on each tree level. A finished result sits in an
// output register, so the next beat is accepted while it waits.
module cheapest_k_units_cost_tree #(
   parameter int unsigned PRICE_LEVELS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [10:0] req_price,
   input  wire logic [23:0] req_unit_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [47:0]      rsp_day_cost,
   output logic [62:0]      rsp_running_total,
   output logic             rsp_rejected,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data
);

   ckuct_pkg::cmd_type    cmd;
   ckuct_pkg::status_type status;

   ckuct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ckuct_dp #(.PRICE_LEVELS(PRICE_LEVELS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_price         (req_price),
      .req_unit_count    (req_unit_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_day_cost      (rsp_day_cost),
      .rsp_running_total (rsp_running_total),
      .rsp_rejected      (rsp_rejected)
   );

`ifndef ASSERT_OFF
   // a rejection beat carries no day cost
   a_reject_zero_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_day_cost == '0))
      else $error("rejection beat with nonzero day cost");

   // clearing pass blocks requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing pass");

   // one item at a time: no back-to-back accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted while busy");
`endif

endmodule
`default_nettype wire
